[design/base64_line_encoder_macros.svh]
// Assertion macros for the base64 line encoder checker.
// Expects clk and arst_n to be visible where the macros are used.
`ifndef BASE64_LINE_ENCODER_MACROS_SVH
`define BASE64_LINE_ENCODER_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define B64LW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define B64LW_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/b64lw_pkg.sv]
// Shared types, constants and the alphabet function of the base64 line encoder.
// No dependencies.
`default_nettype none

package b64lw_pkg;

	localparam int LINE_CHARS_DEF  = 64;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int COL_W           = 7;
	localparam int NUM_STEPS       = 6;
	localparam int STEP_W          = 3;

	localparam logic [7:0] LF_CHAR  = 8'd10;
	localparam logic [7:0] PAD_CHAR = 8'd61;

	// Character slots of one job, in emission order.
	localparam logic [STEP_W-1:0] STEP_LF_PRE  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_C0      = 3'd1;
	localparam logic [STEP_W-1:0] STEP_C1      = 3'd2;
	localparam logic [STEP_W-1:0] STEP_C2      = 3'd3;
	localparam logic [STEP_W-1:0] STEP_C3      = 3'd4;
	localparam logic [STEP_W-1:0] STEP_LF_POST = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_data;
		logic       end_of_stream;
	} byte_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_of_run;
	} char_item_t;

	// One unit of work for the back end: optional wrap, optional group, optional close.
	typedef struct packed {
		logic       lf_pre;
		logic       grp;
		logic [1:0] nbytes;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       lf_post;
	} job_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'd65 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'd71 + {2'b00, v};
		end else if (v < 6'd62) begin
			c = {2'b00, v} - 8'd4;
		end else if (v == 6'd62) begin
			c = 8'd43;
		end else begin
			c = 8'd47;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[design/b64lw_front.sv]
// Front end: takes input bytes, gathers groups of three, tracks the line column
// and hands complete jobs to the queue. Uses b64lw_pkg.
`default_nettype none

module b64lw_front #(
	parameter int LINE_CHARS = b64lw_pkg::LINE_CHARS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire b64lw_pkg::byte_item_t item,
	output      logic                  push,
	output      b64lw_pkg::job_t       job
);

	localparam int CW = b64lw_pkg::COL_W;

	logic [15:0]   held_q, held_d;
	logic [1:0]    cnt_q, cnt_d;
	logic [CW-1:0] col_q, col_d, col_base;
	logic          lf_pre;

	always_comb begin
		job      = '0;
		held_d   = held_q;
		cnt_d    = cnt_q;
		col_d    = col_q;
		lf_pre   = (col_q >= CW'(LINE_CHARS));
		col_base = lf_pre ? '0 : col_q;
		push     = (item.has_data && cnt_q == 2'd2) || item.end_of_stream;

		if (item.has_data && cnt_q == 2'd2) begin
			job.lf_pre  = lf_pre;
			job.grp     = 1'b1;
			job.nbytes  = 2'd3;
			job.b0      = held_q[15:8];
			job.b1      = held_q[7:0];
			job.b2      = item.data_byte;
			job.lf_post = item.end_of_stream;
			held_d      = '0;
			cnt_d       = '0;
			col_d       = item.end_of_stream ? '0 : col_base + CW'(4);
		end else if (item.end_of_stream) begin
			job.lf_post = 1'b1;
			held_d      = '0;
			cnt_d       = '0;
			col_d       = '0;
			if (item.has_data) begin
				job.lf_pre = lf_pre;
				job.grp    = 1'b1;
				if (cnt_q == 2'd0) begin
					job.nbytes = 2'd1;
					job.b0     = item.data_byte;
				end else begin
					job.nbytes = 2'd2;
					job.b0     = held_q[7:0];
					job.b1     = item.data_byte;
				end
			end else if (cnt_q != 2'd0) begin
				job.lf_pre = lf_pre;
				job.grp    = 1'b1;
				if (cnt_q == 2'd1) begin
					job.nbytes = 2'd1;
					job.b0     = held_q[7:0];
				end else begin
					job.nbytes = 2'd2;
					job.b0     = held_q[15:8];
					job.b1     = held_q[7:0];
				end
			end
		end else if (item.has_data) begin
			held_d = {held_q[7:0], item.data_byte};
			cnt_d  = cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			cnt_q  <= '0;
			col_q  <= '0;
		end else if (accept) begin
			held_q <= held_d;
			cnt_q  <= cnt_d;
			col_q  <= col_d;
		end
	end

endmodule

`default_nettype wire

[design/b64lw_fifo.sv]
// Short register queue of jobs between front and back end.
// Uses b64lw_pkg for the job type.
`default_nettype none

module b64lw_fifo #(
	parameter int DEPTH = b64lw_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire b64lw_pkg::job_t wr_job,
	output      logic            full,
	input  wire logic            pop,
	output      logic            empty,
	output      b64lw_pkg::job_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	b64lw_pkg::job_t slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]   count_q;

	assign full  = (count_q == NW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

`default_nettype wire

[design/b64lw_back.sv]
// Back end: walks the character slots of the job at the queue head and
// drives the output register, one character per cycle while a job is queued and char_ready is high. Uses b64lw_pkg.
`default_nettype none

module b64lw_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  empty,
	input  wire b64lw_pkg::job_t       head,
	output      logic                  pop,
	output      logic                  char_valid,
	input  wire logic                  char_ready,
	output      b64lw_pkg::char_item_t char_item
);

	localparam int NS = b64lw_pkg::NUM_STEPS;
	localparam int SW = b64lw_pkg::STEP_W;

	logic [SW-1:0]         step_q, cur;
	logic [NS-1:0]         en, pending;
	logic                  found, last, load;
	logic [7:0]            ch;
	logic                  valid_q;
	b64lw_pkg::char_item_t item_q;

	assign en = {head.lf_post, {4{head.grp}}, head.lf_pre};

	// Lowest enabled slot at or after step_q; last when nothing remains above it.
	always_comb begin
		cur   = '0;
		found = 1'b0;
		last  = 1'b1;
		for (int i = 0; i < NS; i++) begin
			pending[i] = en[i] && (SW'(i) >= step_q);
		end
		for (int i = 0; i < NS; i++) begin
			if (pending[i] && !found) begin
				cur   = SW'(i);
				found = 1'b1;
			end else if (pending[i]) begin
				last = 1'b0;
			end
		end
	end

	always_comb begin
		case (cur)
			b64lw_pkg::STEP_LF_PRE:  ch = b64lw_pkg::LF_CHAR;
			b64lw_pkg::STEP_C0:      ch = b64lw_pkg::b64_char(head.b0[7:2]);
			b64lw_pkg::STEP_C1:      ch = b64lw_pkg::b64_char({head.b0[1:0], head.b1[7:4]});
			b64lw_pkg::STEP_C2:      ch = (head.nbytes >= 2'd2) ?
			                              b64lw_pkg::b64_char({head.b1[3:0], head.b2[7:6]}) :
			                              b64lw_pkg::PAD_CHAR;
			b64lw_pkg::STEP_C3:      ch = (head.nbytes == 2'd3) ?
			                              b64lw_pkg::b64_char(head.b2[5:0]) :
			                              b64lw_pkg::PAD_CHAR;
			b64lw_pkg::STEP_LF_POST: ch = b64lw_pkg::LF_CHAR;
			default:                 ch = b64lw_pkg::LF_CHAR;
		endcase
	end

	assign load = !empty && (!valid_q || char_ready);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				step_q  <= last ? '0 : cur + SW'(1);
			end else if (char_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q.out_char    <= ch;
			item_q.last_of_run <= last;
		end
	end

	assign char_valid = valid_q;
	assign char_item  = item_q;

endmodule

`default_nettype wire

[design/base64_line_encoder.sv]
// Base64 line encoder: byte stream in, wrapped base64 character stream out.
// Top level; instantiates b64lw_front, b64lw_fifo and b64lw_back, uses b64lw_pkg.
//
// Usage:
//   byte channel (byte_valid/byte_ready/byte_item): one byte per request, with
//   has_data and end_of_stream flags. A bare end marker closes the line.
//   char channel (char_valid/char_ready/char_item): one character per request;
//   last_of_run marks the final character caused by an input request.
// Path: a taken request is first written into the job queue; its first character
//   is then loaded into the output register when nothing is queued ahead of it.
// Throughput: one character per cycle on the output while char_ready is high; an
//   input request is taken every cycle while the job queue has room, so a steady
//   stream of bytes is limited by the output port (four characters per three
//   bytes plus a line feed at each wrap).
// Requests that cause no characters are still taken only while the queue has room.
// Reset: clears the held bytes, line column, queue and output register; no
//   output is valid until new input arrives.
// Stall: a held char_ready low freezes the output register; the queue then
//   fills (QUEUE_DEPTH jobs) and byte_ready drops until the receiver resumes.
`default_nettype none

module base64_line_encoder #(
	parameter int LINE_CHARS  = b64lw_pkg::LINE_CHARS_DEF,
	parameter int QUEUE_DEPTH = b64lw_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  byte_valid,
	output      logic                  byte_ready,
	input  wire b64lw_pkg::byte_item_t byte_item,
	output      logic                  char_valid,
	input  wire logic                  char_ready,
	output      b64lw_pkg::char_item_t char_item
);

	logic            accept, push, full, pop, empty;
	b64lw_pkg::job_t job, head;

	assign byte_ready = !full;
	assign accept     = byte_valid && byte_ready;

	b64lw_front #(
		.LINE_CHARS(LINE_CHARS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (byte_item),
		.push   (push),
		.job    (job)
	);

	b64lw_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept && push),
		.wr_job (job),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.head   (head)
	);

	b64lw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.head       (head),
		.pop        (pop),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item)
	);

endmodule

`default_nettype wire

[design/b64lw_checker.sv]
// Port-level checker for the base64 line encoder, bound to the top level.
// Uses b64lw_pkg and base64_line_encoder_macros.svh.
`default_nettype none
`include "base64_line_encoder_macros.svh"

module b64lw_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  char_valid,
	input wire logic                  char_ready,
	input wire b64lw_pkg::char_item_t char_item
);

	logic char_stall, char_lf, char_pad, wrap_lf;

	assign char_stall = char_valid && !char_ready;
	assign char_lf    = char_valid && (char_item.out_char == b64lw_pkg::LF_CHAR);
	assign char_pad   = char_valid && (char_item.out_char == b64lw_pkg::PAD_CHAR);
	// a line feed that is taken and is not the end of its run is a wrap
	assign wrap_lf    = char_lf && char_ready && !char_item.last_of_run;

	`B64LW_ASSERT_ALWAYS(a_idle_in_reset, !arst_n |-> !char_valid, "output valid during reset")
	`B64LW_ASSERT(a_hold_on_stall, char_stall |=> char_valid && $stable(char_item), "stalled char changed")
	`B64LW_ASSERT(a_pad_not_last, char_pad |-> !char_item.last_of_run, "pad ends a run")
	`B64LW_ASSERT(a_no_blank_line, wrap_lf |=> !char_lf, "two line feeds in one run")

endmodule

bind base64_line_encoder b64lw_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.char_valid (char_valid),
	.char_ready (char_ready),
	.char_item  (char_item)
);

`default_nettype wire

[test/base64_line_encoder_checker.sv]
// Watches both channels of the base64 line encoder, predicts the characters and compares them.
// Depends on b64lw_pkg for the request and character types and the line feed and pad codes.
module base64_line_encoder_checker #(
	parameter int LINE_CHARS = b64lw_pkg::LINE_CHARS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	input  logic                  byte_ready,
	input  b64lw_pkg::byte_item_t byte_item,
	input  logic                  char_valid,
	input  logic                  char_ready,
	input  b64lw_pkg::char_item_t char_item,
	output int                    errors,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// first character sits in the top byte
	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	logic [15:0] held_bytes = '0;
	logic [1:0]  held_count = '0;
	logic [6:0]  line_column = '0;

	b64lw_pkg::char_item_t expected_chars[$];
	b64lw_pkg::char_item_t run_chars [0:5];
	b64lw_pkg::char_item_t want;
	int run_len;
	int fail_count = 0;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		return ALPHABET[8*(63-v) +: 8];
	endfunction

	function automatic void add_char(input logic [7:0] c);
		run_chars[run_len] = '{out_char: c, last_of_run: 1'b0};
		run_len++;
	endfunction

	// word holds up to three bytes, oldest in the top byte, zero-filled
	function automatic void add_group(input logic [23:0] word, input int nbytes);
		if (line_column >= LINE_CHARS) begin
			add_char(b64lw_pkg::LF_CHAR);
			line_column = '0;
		end
		add_char(sextet_char(word[23:18]));
		add_char(sextet_char(word[17:12]));
		add_char(nbytes >= 2 ? sextet_char(word[11:6]) : b64lw_pkg::PAD_CHAR);
		add_char(nbytes >= 3 ? sextet_char(word[5:0]) : b64lw_pkg::PAD_CHAR);
		line_column = line_column + 7'd4;
	endfunction

	function automatic void encode_request(input b64lw_pkg::byte_item_t req);
		b64lw_pkg::char_item_t c;
		run_len = 0;
		if (req.has_data) begin
			if (held_count == 2'd2) begin
				add_group({held_bytes, req.data_byte}, 3);
				held_bytes = '0;
				held_count = '0;
			end else begin
				held_bytes = {held_bytes[7:0], req.data_byte};
				held_count = held_count + 2'd1;
			end
		end
		if (req.end_of_stream) begin
			if (held_count == 2'd1) begin
				add_group({held_bytes[7:0], 16'h0000}, 1);
			end else if (held_count == 2'd2) begin
				add_group({held_bytes, 8'h00}, 2);
			end
			add_char(b64lw_pkg::LF_CHAR);
			held_bytes = '0;
			held_count = '0;
			line_column = '0;
		end
		for (int i = 0; i < run_len; i++) begin
			c = run_chars[i];
			c.last_of_run = (i == run_len - 1);
			expected_chars.push_back(c);
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			held_bytes = '0;
			held_count = '0;
			line_column = '0;
			expected_chars.delete();
		end else begin
			if (char_valid && char_ready) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected char: expected none, actual %h last %b",
						$time, char_item.out_char, char_item.last_of_run);
					fail_count++;
				end else begin
					want = expected_chars.pop_front();
					if (char_item.out_char !== want.out_char) begin
						$display("%0t: out_char: expected %h, actual %h",
							$time, want.out_char, char_item.out_char);
						fail_count++;
					end
					if (char_item.last_of_run !== want.last_of_run) begin
						$display("%0t: last_of_run: expected %b, actual %b",
							$time, want.last_of_run, char_item.last_of_run);
						fail_count++;
					end
				end
			end
			// a request taken now cannot have produced a character at this same edge
			if (byte_valid && byte_ready) begin
				encode_request(byte_item);
			end
		end
		errors <= fail_count;
		pending <= expected_chars.size();
	end

endmodule

[test/base64_line_encoder_tb.sv]
// Top of the base64 line encoder testbench: clock, reset, request stimulus and verdict.
// Depends on b64lw_pkg, base64_line_encoder and base64_line_encoder_checker.
module base64_line_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_CHARS     = b64lw_pkg::LINE_CHARS_DEF;
	localparam int TOTAL_REQUESTS = 330;
	localparam int DIRECTED       = 16;
	localparam int STALL_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 20;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  byte_valid = 1'b0;
	logic                  byte_ready;
	b64lw_pkg::byte_item_t byte_item = '0;
	logic                  char_valid;
	logic                  char_ready = 1'b0;
	b64lw_pkg::char_item_t char_item;

	int errors;
	int pending;
	int requests_sent = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	base64_line_encoder #(
		.LINE_CHARS(LINE_CHARS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item(byte_item),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_item(char_item)
	);

	base64_line_encoder_checker #(
		.LINE_CHARS(LINE_CHARS)
	) stream_check (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item(byte_item),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_item(char_item),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		char_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((byte_valid && byte_ready) || (char_valid && char_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_request(input logic [7:0] data, input logic has_data, input logic eos);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= '{data_byte: data, has_data: has_data, end_of_stream: eos};
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		requests_sent++;
	endtask

	// One stream of random bytes; lengths near 48 land on the full-line boundary.
	task automatic send_stream();
		int kind;
		int len;
		bit close_with_data;
		kind = $urandom_range(0, 19);
		if (kind < 15) begin
			len = $urandom_range(0, 8);
		end else if (kind < 19) begin
			len = $urandom_range(47, 49);
		end else begin
			len = $urandom_range(95, 97);
		end
		close_with_data = (len > 0) && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
			send_request(8'($urandom_range(0, 255)), 1'b1,
				close_with_data && (i == len - 1));
		end
		if (!close_with_data) begin
			send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
	endtask

	task automatic hold_until_drained();
		byte_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bare end marker on an empty stream, then a request carrying nothing
		send_request(8'h00, 1'b0, 1'b1);
		send_request(8'hff, 1'b0, 1'b0);
		// single byte with the end mark: two pads
		send_request(8'h00, 1'b1, 1'b1);
		// two bytes, end mark on the second: one pad
		send_request(8'hff, 1'b1, 1'b0);
		send_request(8'hff, 1'b1, 1'b1);
		// full group whose four sextets are all 62 ('+'), then bare end marker with nothing held
		send_request(8'hfb, 1'b1, 1'b0);
		send_request(8'hef, 1'b1, 1'b0);
		send_request(8'hbe, 1'b1, 1'b0);
		send_request(8'h00, 1'b0, 1'b1);
		// end mark on the byte that completes a group
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'hff, 1'b1, 1'b0);
		send_request(8'h7f, 1'b1, 1'b1);
		// empty request in the middle of a group, then flush of two held bytes
		send_request(8'h80, 1'b1, 1'b0);
		send_request(8'h55, 1'b0, 1'b0);
		send_request(8'h01, 1'b1, 1'b0);
		send_request(8'haa, 1'b0, 1'b1);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 87;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 87;
				end
				default: begin
					send_idle_pct = 33;
					recv_stall_pct = 33;
				end
			endcase
			while (requests_sent < DIRECTED + (phase + 1) * (TOTAL_REQUESTS - DIRECTED) / 4)
				send_stream();
			// sender holds off until every expected character is back
			hold_until_drained();
		end

		recv_stall_pct = 0;
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
